/* design/bpp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared constants and the command/status structs that join the packet
// parser's controller and datapath.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned RAW_W  = 16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hAA;
  localparam logic [BYTE_W-1:0] EXT_BYTE     = 8'h55;
  localparam logic [BYTE_W-1:0] CODE_QUALITY = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_HEART   = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_RAW     = 8'h80;

  // Controller to datapath
  typedef struct packed {
    logic len_load;   // latch length, clear count and sum
    logic data_wr;    // store payload byte, accumulate sum
    logic chk_take;   // checksum byte: clear results, set status, rewind walk
    logic rd_pos;     // read payload at walk position
    logic rd_pos1;    // read payload at walk position + 1
    logic set_ext;    // extension prefix seen
    logic take_code;  // latch row code
    logic take_len;   // latch row length
    logic take_v0;    // first value byte
    logic take_v1;    // second value byte (raw wave low byte)
    logic next_row;   // skip row value bytes, clear extension level
    logic out_load;   // move result into output register
  } bpp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sync;       // incoming byte is sync
    logic len_bad;    // incoming length is zero or too large
    logic data_last;  // this payload byte completes the payload
    logic check_ok;   // incoming byte matches inverted sum
    logic pos_end;    // walk position at or past payload end
    logic rd_ext;     // read byte is an extension prefix
    logic rd_long;    // read byte is a multi-byte code
    logic row_over;   // row value bytes run past payload end
    logic row_use;    // row carries a value of interest
    logic code_raw;   // current row is raw wave
    logic out_free;   // output register can take a result
  } bpp_sts_t;

endpackage
`default_nettype wire

/* design/bpp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_ctrl
// Frame and row-walk sequencer: hunts sync, counts the payload in, then
// steps through the stored payload row by row.
// ----------------------------------------------------------------------------
module bpp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bpp_pkg::bpp_sts_t sts_i,
  output bpp_pkg::bpp_cmd_t      cmd_o
);
  import bpp_pkg::*;

  typedef enum logic [12:0] {
    S_SYNC1 = 13'b0000000000001,
    S_SYNC2 = 13'b0000000000010,
    S_LEN   = 13'b0000000000100,
    S_DATA  = 13'b0000000001000,
    S_CHECK = 13'b0000000010000,
    S_W_RD  = 13'b0000000100000,
    S_W_PFX = 13'b0000001000000,
    S_W_LRD = 13'b0000010000000,
    S_W_LEN = 13'b0000100000000,
    S_W_CHK = 13'b0001000000000,
    S_W_V0  = 13'b0010000000000,
    S_W_V1  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } bpp_state_e;

  bpp_state_e state_q, state_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  // Bytes are taken only in the framing states
  always_comb begin
    in_stall_o = !(state_q == S_SYNC1 || state_q == S_SYNC2 || state_q == S_LEN ||
                   state_q == S_DATA  || state_q == S_CHECK);
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_SYNC1: begin
        if (accept && sts_i.sync) state_d = S_SYNC2;
      end
      S_SYNC2: begin
        if (accept) state_d = sts_i.sync ? S_LEN : S_SYNC1;
      end
      S_LEN: begin
        // a sync byte in the length slot is skipped
        if (accept && !sts_i.sync) begin
          if (sts_i.len_bad) begin
            state_d = S_SYNC1;
          end else begin
            cmd_o.len_load = 1'b1;
            state_d        = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd_o.data_wr = 1'b1;
          if (sts_i.data_last) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (accept) begin
          cmd_o.chk_take = 1'b1;
          state_d        = sts_i.check_ok ? S_W_RD : S_DONE;
        end
      end
      S_W_RD: begin
        if (sts_i.pos_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_pos = 1'b1;
          state_d      = S_W_PFX;
        end
      end
      S_W_PFX: begin
        if (sts_i.rd_ext) begin
          cmd_o.set_ext = 1'b1;
          state_d       = S_W_RD;
        end else begin
          cmd_o.take_code = 1'b1;
          state_d         = sts_i.rd_long ? S_W_LRD : S_W_CHK;
        end
      end
      S_W_LRD: begin
        if (sts_i.pos_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_pos = 1'b1;
          state_d      = S_W_LEN;
        end
      end
      S_W_LEN: begin
        cmd_o.take_len = 1'b1;
        state_d        = S_W_CHK;
      end
      S_W_CHK: begin
        if (sts_i.row_over) begin
          state_d = S_DONE;
        end else if (sts_i.row_use) begin
          cmd_o.rd_pos = 1'b1;
          state_d      = S_W_V0;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d        = S_W_RD;
        end
      end
      S_W_V0: begin
        cmd_o.take_v0 = 1'b1;
        if (sts_i.code_raw) begin
          cmd_o.rd_pos1 = 1'b1;
          state_d       = S_W_V1;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d        = S_W_RD;
        end
      end
      S_W_V1: begin
        cmd_o.take_v1  = 1'b1;
        cmd_o.next_row = 1'b1;
        state_d        = S_W_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_SYNC1;
        end
      end
      default: begin
        state_d = S_SYNC1;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/bpp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_dp
// Payload store, length/count/sum registers, row walk registers, result
// collection and the output register.
// ----------------------------------------------------------------------------
module bpp_dp #(
  parameter int unsigned MAX_PAYLOAD = 169
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [bpp_pkg::BYTE_W-1:0]     rx_byte_i,
  input  wire bpp_pkg::bpp_cmd_t              cmd_i,
  output bpp_pkg::bpp_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                status_o,
  output logic [bpp_pkg::BYTE_W-1:0]          signal_quality_o,
  output logic                                has_signal_quality_o,
  output logic [bpp_pkg::BYTE_W-1:0]          heart_rate_o,
  output logic                                has_heart_rate_o,
  output logic signed [bpp_pkg::RAW_W-1:0]    raw_wave_o,
  output logic                                has_raw_wave_o
);
  import bpp_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rdata_q;

  logic [BYTE_W-1:0] length_q, count_q, sum_q;
  logic [POS_W-1:0]  pos_q, pos_inc, row_end, rd_addr;
  logic              ext_q;
  logic [BYTE_W-1:0] code_q, rlen_q, v0_q;

  logic              bad_q, has_sq_q, has_hr_q, has_raw_q;
  logic [BYTE_W-1:0] sq_q, hr_q;
  logic [RAW_W-1:0]  raw_q;
  logic              out_valid_q;

  assign pos_inc = pos_q + POS_W'(1);
  assign row_end = pos_q + {1'b0, rlen_q};
  assign rd_addr = cmd_i.rd_pos1 ? pos_inc : pos_q;

  // Status
  always_comb begin
    sts_o           = '0;
    sts_o.sync      = (rx_byte_i == SYNC_BYTE);
    sts_o.len_bad   = (rx_byte_i == '0) || ({1'b0, rx_byte_i} > MAX_LEN);
    sts_o.data_last = ({1'b0, count_q} + POS_W'(1)) >= {1'b0, length_q};
    sts_o.check_ok  = (rx_byte_i == ~sum_q);
    sts_o.pos_end   = (pos_q >= {1'b0, length_q});
    sts_o.rd_ext    = (rdata_q == EXT_BYTE);
    sts_o.rd_long   = (rdata_q >= CODE_RAW);
    sts_o.row_over  = (row_end > {1'b0, length_q});
    sts_o.row_use   = !ext_q && ((code_q == CODE_QUALITY) || (code_q == CODE_HEART) ||
                                 ((code_q == CODE_RAW) && (rlen_q >= BYTE_W'(2))));
    sts_o.code_raw  = (code_q == CODE_RAW);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_wr) begin
      mem[count_q[AW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_pos || cmd_i.rd_pos1) begin
      rdata_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // Frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
      count_q  <= '0;
      sum_q    <= '0;
    end else if (cmd_i.len_load) begin
      length_q <= rx_byte_i;
      count_q  <= '0;
      sum_q    <= '0;
    end else if (cmd_i.data_wr) begin
      count_q <= count_q + BYTE_W'(1);
      sum_q   <= sum_q + rx_byte_i;
    end
  end

  // Row walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_take) begin
      pos_q <= '0;
      ext_q <= 1'b0;
    end
    if (cmd_i.set_ext) begin
      pos_q <= pos_inc;
      ext_q <= 1'b1;
    end
    if (cmd_i.take_code) begin
      pos_q  <= pos_inc;
      code_q <= rdata_q;
      rlen_q <= BYTE_W'(1);
    end
    if (cmd_i.take_len) begin
      pos_q  <= pos_inc;
      rlen_q <= rdata_q;
    end
    if (cmd_i.next_row) begin
      pos_q <= row_end;
      ext_q <= 1'b0;
    end
  end

  // Result collection
  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_take) begin
      bad_q     <= !sts_o.check_ok;
      sq_q      <= '0;
      has_sq_q  <= 1'b0;
      hr_q      <= '0;
      has_hr_q  <= 1'b0;
      raw_q     <= '0;
      has_raw_q <= 1'b0;
    end
    if (cmd_i.take_v0) begin
      v0_q <= rdata_q;
      if (code_q == CODE_QUALITY) begin
        sq_q     <= rdata_q;
        has_sq_q <= 1'b1;
      end
      if (code_q == CODE_HEART) begin
        hr_q     <= rdata_q;
        has_hr_q <= 1'b1;
      end
    end
    if (cmd_i.take_v1) begin
      raw_q     <= {v0_q, rdata_q};
      has_raw_q <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o             <= bad_q;
      signal_quality_o     <= sq_q;
      has_signal_quality_o <= has_sq_q;
      heart_rate_o         <= hr_q;
      has_heart_rate_o     <= has_hr_q;
      raw_wave_o           <= raw_q;
      has_raw_wave_o       <= has_raw_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* design/biosensor_packet_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// biosensor_packet_parser
// Sync-framed biosensor packet parser: checksum check and row decode.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the frame is hunted and the payload
// stored. After the checksum byte the input stalls while the stored payload
// is walked through the registered read port of the payload memory, with
// value bytes of uninteresting rows skipped without reading. The slowest
// rows are multi-byte codes with a zero length; the stall grows with the
// payload length, plus any wait for the output register to empty. A request
// on the output carries the last quality, heart rate and raw wave values
// with their present flags, or a checksum-mismatch status with all other
// fields zero.
// ----------------------------------------------------------------------------
module biosensor_packet_parser #(
  parameter int unsigned MAX_PAYLOAD = 169
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bpp_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             status_o,
  output logic [bpp_pkg::BYTE_W-1:0]       signal_quality_o,
  output logic                             has_signal_quality_o,
  output logic [bpp_pkg::BYTE_W-1:0]       heart_rate_o,
  output logic                             has_heart_rate_o,
  output logic signed [bpp_pkg::RAW_W-1:0] raw_wave_o,
  output logic                             has_raw_wave_o
);
  import bpp_pkg::*;

  bpp_cmd_t cmd;
  bpp_sts_t sts;

  bpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .rx_byte_i            (rx_byte_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .signal_quality_o     (signal_quality_o),
    .has_signal_quality_o (has_signal_quality_o),
    .heart_rate_o         (heart_rate_o),
    .has_heart_rate_o     (has_heart_rate_o),
    .raw_wave_o           (raw_wave_o),
    .has_raw_wave_o       (has_raw_wave_o)
  );

endmodule
`default_nettype wire

/* tb/packet_summary_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_summary_checker
// Watches both channels of the packet parser. Every accepted byte goes
// through a local model of the framing and row decode. Each completed packet
// queues one expected summary, and every accepted result is compared field
// by field against the oldest of these.
// ----------------------------------------------------------------------------
module packet_summary_checker #(
  parameter int unsigned MAX_PAYLOAD = 169
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [bpp_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       status_i,
  input  logic [bpp_pkg::BYTE_W-1:0] signal_quality_i,
  input  logic                       has_signal_quality_i,
  input  logic [bpp_pkg::BYTE_W-1:0] heart_rate_i,
  input  logic                       has_heart_rate_i,
  input  logic [bpp_pkg::RAW_W-1:0]  raw_wave_i,
  input  logic                       has_raw_wave_i,
  output int                         errors_o,
  output int                         pending_o
);
  import bpp_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_LENGTH,
    TAKE_DATA,
    TAKE_CHECK
  } frame_phase_e;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] quality;
    logic              has_quality;
    logic [BYTE_W-1:0] heart;
    logic              has_heart;
    logic [RAW_W-1:0]  raw;
    logic              has_raw;
  } packet_summary_t;

  frame_phase_e      phase;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] frame_len;
  logic [BYTE_W-1:0] bytes_seen;
  logic [BYTE_W-1:0] byte_sum;

  packet_summary_t   summary_q [$];
  int                mismatches  = 0;
  int                outstanding = 0;

  assign errors_o  = mismatches;
  assign pending_o = outstanding;

  // Walks the stored payload as rows; the last level-0 value of each kind wins.
  function automatic packet_summary_t decode_rows();
    packet_summary_t   s;
    int                pos;
    int                level;
    int                rlen;
    logic [BYTE_W-1:0] code;
    s   = '0;
    pos = 0;
    while (pos < frame_len) begin
      level = 0;
      while (pos < frame_len && payload_mem[pos] == EXT_BYTE) begin
        level++;
        pos++;
      end
      if (pos >= frame_len) return s;
      code = payload_mem[pos];
      pos++;
      if (code >= CODE_RAW) begin
        if (pos >= frame_len) return s;
        rlen = payload_mem[pos];
        pos++;
      end else begin
        rlen = 1;
      end
      // truncated row ends the walk
      if (pos + rlen > frame_len) return s;
      if (level == 0) begin
        if (code == CODE_QUALITY) begin
          s.quality     = payload_mem[pos];
          s.has_quality = 1'b1;
        end else if (code == CODE_HEART) begin
          s.heart     = payload_mem[pos];
          s.has_heart = 1'b1;
        end else if (code == CODE_RAW && rlen >= 2) begin
          s.raw     = {payload_mem[pos], payload_mem[pos+1]};
          s.has_raw = 1'b1;
        end
      end
      pos += rlen;
    end
    return s;
  endfunction

  task automatic take_byte(input logic [BYTE_W-1:0] b);
    packet_summary_t s;
    case (phase)
      HUNT_FIRST: begin
        if (b == SYNC_BYTE) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        phase = (b == SYNC_BYTE) ? TAKE_LENGTH : HUNT_FIRST;
      end
      TAKE_LENGTH: begin
        // extra sync bytes in the length slot are skipped
        if (b != SYNC_BYTE) begin
          if (b == '0 || b > MAX_PAYLOAD) begin
            phase = HUNT_FIRST;
          end else begin
            frame_len  = b;
            bytes_seen = '0;
            byte_sum   = '0;
            phase      = TAKE_DATA;
          end
        end
      end
      TAKE_DATA: begin
        if (bytes_seen < MAX_PAYLOAD) payload_mem[bytes_seen] = b;
        byte_sum   = byte_sum + b;
        bytes_seen = bytes_seen + 1'b1;
        if (bytes_seen >= frame_len) phase = TAKE_CHECK;
      end
      TAKE_CHECK: begin
        if (b == ~byte_sum) begin
          s = decode_rows();
        end else begin
          s        = '0;
          s.status = 1'b1;
        end
        summary_q.push_back(s);
        outstanding++;
        phase = HUNT_FIRST;
      end
      default: phase = HUNT_FIRST;
    endcase
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    packet_summary_t want;
    if (summary_q.size() == 0) begin
      $display("%0t: result with no packet outstanding, status %0d", $time, status_i);
      mismatches++;
    end else begin
      want = summary_q.pop_front();
      outstanding--;
      check_field("status", want.status, status_i);
      check_field("signal_quality", want.quality, signal_quality_i);
      check_field("has_signal_quality", want.has_quality, has_signal_quality_i);
      check_field("heart_rate", want.heart, heart_rate_i);
      check_field("has_heart_rate", want.has_heart, has_heart_rate_i);
      check_field("raw_wave", $signed(want.raw), $signed(raw_wave_i));
      check_field("has_raw_wave", want.has_raw, has_raw_wave_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = HUNT_FIRST;
      frame_len  = '0;
      bytes_seen = '0;
      byte_sum   = '0;
    end else begin
      // results first: a result leaving now belongs to an older packet
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) take_byte(rx_byte_i);
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the biosensor packet parser.
// Sends a few hand-built frames covering the framing corner cases, then
// random packets with row content, bad checksums and line noise, under
// random idling on both channels. Checking is done by the summary checker.
// ----------------------------------------------------------------------------
module testbench;
  import bpp_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 169;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          LONG_HOLD   = 400;
  localparam int          BYTE_COUNT  = 800;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic              status;
  logic [BYTE_W-1:0] signal_quality;
  logic              has_signal_quality;
  logic [BYTE_W-1:0] heart_rate;
  logic              has_heart_rate;
  logic [RAW_W-1:0]  raw_wave;
  logic              has_raw_wave;
  int                errors;
  int                pending;

  int                cycles        = 0;
  int                bytes_sent    = 0;
  bit                long_hold_req = 1'b0;
  bit                send_eager    = 1'b0;
  logic [BYTE_W-1:0] payload_q [$];

  biosensor_packet_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status),
    .signal_quality_o    (signal_quality),
    .has_signal_quality_o(has_signal_quality),
    .heart_rate_o        (heart_rate),
    .has_heart_rate_o    (has_heart_rate),
    .raw_wave_o          (raw_wave),
    .has_raw_wave_o      (has_raw_wave)
  );

  packet_summary_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .status_i            (status),
    .signal_quality_i    (signal_quality),
    .has_signal_quality_i(has_signal_quality),
    .heart_rate_i        (heart_rate),
    .has_heart_rate_i    (has_heart_rate),
    .raw_wave_i          (raw_wave),
    .has_raw_wave_i      (has_raw_wave),
    .errors_o            (errors),
    .pending_o           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: random hold-off before each request, long hold on demand.
  initial begin
    int  hold;
    bit  eager;
    eager = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) eager = ~eager;
      hold = eager ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid || long_hold_req) break;
      end
    end
  end

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = send_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    bytes_sent++;
  endtask

  // Frames payload_q; a bad checksum has one bit flipped.
  task automatic send_packet(input bit bad_sum, input int extra_syncs);
    logic [BYTE_W-1:0] sum;
    sum = '0;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    repeat (extra_syncs) send_byte(SYNC_BYTE);
    send_byte(BYTE_W'(payload_q.size()));
    foreach (payload_q[i]) begin
      send_byte(payload_q[i]);
      sum = sum + payload_q[i];
    end
    sum = ~sum;
    if (bad_sum) sum = sum ^ (BYTE_W'(1) << $urandom_range(0, 7));
    send_byte(sum);
  endtask

  // Random rows up to the given length; the cut at the end may leave a
  // truncated row, and sometimes one more byte is chopped off on purpose.
  task automatic make_rows(input int target);
    int kind;
    int rlen;
    payload_q.delete();
    while (payload_q.size() < target) begin
      kind = $urandom_range(0, 7);
      case (kind)
        0: begin
          payload_q.push_back(CODE_QUALITY);
          payload_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        1: begin
          payload_q.push_back(CODE_HEART);
          payload_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        2: begin
          payload_q.push_back(CODE_RAW);
          payload_q.push_back(8'd2);
          payload_q.push_back(BYTE_W'($urandom_range(0, 255)));
          payload_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        3, 5: begin
          // raw row of random length, or some other multi-byte code
          payload_q.push_back(kind == 3 ? CODE_RAW : BYTE_W'($urandom_range(129, 255)));
          rlen = $urandom_range(0, 4);
          payload_q.push_back(BYTE_W'(rlen));
          repeat (rlen) payload_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        4: begin
          payload_q.push_back(BYTE_W'($urandom_range(0, 127)));
          payload_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        default: payload_q.push_back(EXT_BYTE);
      endcase
    end
    while (payload_q.size() > target) void'(payload_q.pop_back());
    if (payload_q.size() > 1 && $urandom_range(0, 7) == 0) void'(payload_q.pop_back());
  endtask

  initial begin
    int  choice;
    bit  paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // second byte not sync, zero length, oversized length
    send_byte(SYNC_BYTE);
    send_byte(8'h12);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'(MAX_PAYLOAD + 1));
    // sync in the length slot, quality and heart rate extremes
    payload_q = '{CODE_QUALITY, 8'h00, CODE_HEART, 8'hFF};
    send_packet(1'b0, 1);
    // extended row, short raw row, long raw row with minimum value
    payload_q = '{EXT_BYTE, CODE_QUALITY, 8'h11, CODE_RAW, 8'h01, 8'h33,
                  CODE_RAW, 8'h03, 8'h80, 8'h00, 8'h01};
    send_packet(1'b0, 0);
    payload_q = '{CODE_QUALITY, 8'hC8};
    send_packet(1'b1, 0);

    // long hold on the result side while packets keep coming
    long_hold_req = 1'b1;
    repeat (8) begin
      make_rows($urandom_range(1, 8));
      send_packet(1'b0, 0);
    end
    make_rows(MAX_PAYLOAD);
    send_packet(1'b0, 0);

    while (bytes_sent < BYTE_COUNT) begin
      send_eager = ($urandom_range(0, 4) == 0);
      if (!paused && bytes_sent >= BYTE_COUNT / 2) begin
        // quiet line until every packet has been reported
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      choice = $urandom_range(0, 99);
      if (choice < 87) begin
        if ($urandom_range(0, 39) == 0) make_rows($urandom_range(17, MAX_PAYLOAD));
        else make_rows($urandom_range(1, 16));
        send_packet(choice >= 75, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
      end else if (choice < 94) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_byte(SYNC_BYTE);
        case ($urandom_range(0, 2))
          0: send_byte(BYTE_W'($urandom_range(0, 169)));
          1: begin
            send_byte(SYNC_BYTE);
            send_byte(8'h00);
          end
          default: begin
            send_byte(SYNC_BYTE);
            send_byte(BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)));
          end
        endcase
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (2 * MAX_PAYLOAD + 50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
